### rtl/core/sdtq_pkg.sv
// package for the sorted deadline timer queue
// shared types and constants; no dependencies
package sdtq_pkg;

    localparam int SLOT_W     = 4;
    localparam int IN_TIME_W  = 32;
    localparam int OUT_TIME_W = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CHECK  = 2'd2,
        MODE_FLUSH  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DROP,
        ST_INSERT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DROP,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     later;
    } cell_ctrl_t;

endpackage

### rtl/core/sorted_deadline_timer_queue.sv
// sorted deadline timer queue: chain of cells kept in deadline order
// update steps through accept, drop and insert; insert is skipped on disarm or no change
// remove steps through accept and drop; check and flush pop each expiry in the emit state
// expiries are held back by m_tready; one item at a time
// results leave through an output register, loaded in the emit state after the transfer
// reset clears every cell valid bit, the output valid bit and the sequencer
module sorted_deadline_timer_queue #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sdtq_pkg::S_TDATA_W-1:0]     s_tdata,  // slot[3:0], deadline[35:4], now[67:36]
    input  logic [sdtq_pkg::S_TUSER_W-1:0]     s_tuser,  // mode[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sdtq_pkg::M_TDATA_W-1:0]     m_tdata,  // expired_slot[3:0], fired_at[35:4]
    output logic                               m_tlast
);

    localparam int SW = sdtq_pkg::SLOT_W;

    sdtq_pkg::state_t     state_reg, state_next;
    sdtq_pkg::mode_t      mode_reg, in_mode;
    sdtq_pkg::cell_ctrl_t ctrl;

    logic [SW-1:0]        slot_reg, in_slot;
    logic [TIME_BITS-1:0] dl_reg, now_reg, old_reg, old_dl, in_dl, in_now;

    logic                 out_valid_reg, out_valid_next, out_last_reg, out_load, out_last;
    logic [SW-1:0]        out_slot_reg;
    logic [sdtq_pkg::OUT_TIME_W-1:0] out_time_reg;

    logic                 c_valid [SLOTS];
    logic [SW-1:0]        c_slot  [SLOTS];
    logic [TIME_BITS-1:0] c_dl    [SLOTS];
    logic [TIME_BITS-1:0] c_hit_dl[SLOTS];
    logic                 c_cond  [SLOTS];
    logic                 c_chain [SLOTS];
    logic                 head_exp, next_exp, flush, accept, in_range;

    assign in_mode  = sdtq_pkg::mode_t'(s_tuser[1:0]);
    assign in_slot  = s_tdata[SW-1:0];
    assign in_dl    = TIME_BITS'(s_tdata[35:4]);
    assign in_now   = TIME_BITS'(s_tdata[67:36]);
    assign in_range = int'(in_slot) < SLOTS;

    assign s_tready = (state_reg == sdtq_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            logic                 p_valid, n_valid, p_cond, ch_in;
            logic [SW-1:0]        p_slot, n_slot;
            logic [TIME_BITS-1:0] p_dl, n_dl;

            if (gi == 0)
            begin : g_head
                assign p_valid = 1'b0;
                assign p_slot  = '0;
                assign p_dl    = '0;
                assign p_cond  = 1'b0;
                assign ch_in   = 1'b0;
            end
            else
            begin : g_body
                assign p_valid = c_valid[gi-1];
                assign p_slot  = c_slot[gi-1];
                assign p_dl    = c_dl[gi-1];
                assign p_cond  = c_cond[gi-1];
                assign ch_in   = c_chain[gi-1];
            end

            if (gi == SLOTS - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_slot  = '0;
                assign n_dl    = '0;
            end
            else
            begin : g_inner
                assign n_valid = c_valid[gi+1];
                assign n_slot  = c_slot[gi+1];
                assign n_dl    = c_dl[gi+1];
            end

            sdtq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key_slot   (slot_reg),
                .key_time   (dl_reg),
                .prev_valid (p_valid),
                .prev_slot  (p_slot),
                .prev_dl    (p_dl),
                .prev_cond  (p_cond),
                .next_valid (n_valid),
                .next_slot  (n_slot),
                .next_dl    (n_dl),
                .chain_in   (ch_in),
                .valid      (c_valid[gi]),
                .slot       (c_slot[gi]),
                .dl         (c_dl[gi]),
                .cond       (c_cond[gi]),
                .chain_out  (c_chain[gi]),
                .hit_dl     (c_hit_dl[gi])
            );
        end
    endgenerate

    always_comb
    begin
        old_dl = '0;
        for (int i = 0; i < SLOTS; i++)
            old_dl = old_dl | c_hit_dl[i];
    end

    assign flush    = (mode_reg == sdtq_pkg::MODE_FLUSH);
    assign head_exp = c_valid[0] && (flush || (c_dl[0] <= now_reg));
    assign next_exp = c_valid[1] && (flush || (c_dl[1] <= now_reg));

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = sdtq_pkg::CELL_HOLD;
        ctrl.later = dl_reg > old_reg;
        out_load   = 1'b0;
        out_last   = !next_exp;
        case (state_reg)
            sdtq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        sdtq_pkg::MODE_UPDATE:
                            state_next = in_range ? sdtq_pkg::ST_DROP : sdtq_pkg::ST_IDLE;
                        sdtq_pkg::MODE_REMOVE:
                            state_next = sdtq_pkg::ST_DROP;
                        default:
                            state_next = sdtq_pkg::ST_EMIT;
                    endcase
                end
            end
            sdtq_pkg::ST_DROP:
            begin
                state_next = sdtq_pkg::ST_IDLE;
                if (mode_reg == sdtq_pkg::MODE_UPDATE)
                begin
                    if (old_dl != dl_reg)
                    begin
                        ctrl.op = sdtq_pkg::CELL_DROP;
                        if (dl_reg != '0)
                            state_next = sdtq_pkg::ST_INSERT;
                    end
                end
                else
                begin
                    ctrl.op = sdtq_pkg::CELL_DROP;
                end
            end
            sdtq_pkg::ST_INSERT:
            begin
                ctrl.op    = sdtq_pkg::CELL_INSERT;
                state_next = sdtq_pkg::ST_IDLE;
            end
            sdtq_pkg::ST_EMIT:
            begin
                if (!head_exp)
                begin
                    state_next = sdtq_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    ctrl.op  = sdtq_pkg::CELL_POP;
                    out_load = 1'b1;
                    if (out_last)
                        state_next = sdtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_mode;
            slot_reg <= in_slot;
            dl_reg   <= in_dl;
            now_reg  <= in_now;
        end
        if (state_reg == sdtq_pkg::ST_DROP)
            old_reg <= old_dl;
        if (out_load)
        begin
            out_slot_reg <= c_slot[0];
            out_time_reg <= sdtq_pkg::OUT_TIME_W'(now_reg);
            out_last_reg <= out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_time_reg, out_slot_reg};

endmodule

### rtl/core/sdtq_cell.sv
// one list position of the sorted timer chain: valid, slot and deadline
// depends on sdtq_pkg
module sdtq_cell #(
    parameter int TIME_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sdtq_pkg::cell_ctrl_t      ctrl,
    input  logic [sdtq_pkg::SLOT_W-1:0] key_slot,
    input  logic [TIME_BITS-1:0]      key_time,
    input  logic                      prev_valid,
    input  logic [sdtq_pkg::SLOT_W-1:0] prev_slot,
    input  logic [TIME_BITS-1:0]      prev_dl,
    input  logic                      prev_cond,
    input  logic                      next_valid,
    input  logic [sdtq_pkg::SLOT_W-1:0] next_slot,
    input  logic [TIME_BITS-1:0]      next_dl,
    input  logic                      chain_in,
    output logic                      valid,
    output logic [sdtq_pkg::SLOT_W-1:0] slot,
    output logic [TIME_BITS-1:0]      dl,
    output logic                      cond,
    output logic                      chain_out,
    output logic [TIME_BITS-1:0]      hit_dl
);

    logic                        valid_reg, valid_next;
    logic [sdtq_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [TIME_BITS-1:0]        dl_reg, dl_next;
    logic                        hit;

    assign hit       = valid_reg && (slot_reg == key_slot);
    assign chain_out = chain_in | hit;
    assign hit_dl    = hit ? dl_reg : '0;
    assign cond      = !valid_reg || (ctrl.later ? (dl_reg >= key_time) : (dl_reg > key_time));
    assign valid     = valid_reg;
    assign slot      = slot_reg;
    assign dl        = dl_reg;

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        dl_next    = dl_reg;
        case (ctrl.op)
            sdtq_pkg::CELL_DROP:
            begin
                if (chain_out)
                begin
                    valid_next = next_valid;
                    slot_next  = next_slot;
                    dl_next    = next_dl;
                end
            end
            sdtq_pkg::CELL_POP:
            begin
                valid_next = next_valid;
                slot_next  = next_slot;
                dl_next    = next_dl;
            end
            sdtq_pkg::CELL_INSERT:
            begin
                if (prev_cond)
                begin
                    valid_next = prev_valid;
                    slot_next  = prev_slot;
                    dl_next    = prev_dl;
                end
                else if (cond)
                begin
                    valid_next = 1'b1;
                    slot_next  = key_slot;
                    dl_next    = key_time;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        dl_reg   <= dl_next;
    end

endmodule
